// File: hw/rtl/tcce_pkg.sv
// Shared types and constants of the text console character engine.
// Depends on nothing; the interface files and the core import it.
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

	// Default screen geometry.
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Fixed field widths of the request and result channels.
	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int POS_W   = 11;
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;

	// Configuration port.
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam logic REG_ATTR = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_DELETE    = 8'h7F;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
	localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

endpackage

`default_nettype wire

// File: hw/rtl/tcce_cmd_if.sv
// Request channel of the text console character engine: valid/ready and payload.
// Depends on tcce_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcce_cmd_if;
	import tcce_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [CHAR_W-1:0]   char_code;
	logic [COL_W-1:0]    col;
	logic [ROW_W-1:0]    row;

	modport source (output valid, output cmd, output char_code, output col, output row,
		input ready);
	modport sink (input valid, input cmd, input char_code, input col, input row,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcce_res_if.sv
// Result channel of the text console character engine: valid/ready and payload.
// Depends on tcce_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcce_res_if;
	import tcce_pkg::*;

	logic                valid;
	logic                ready;
	logic [COL_W-1:0]    cursor_col;
	logic [ROW_W-1:0]    cursor_row;
	logic [POS_W-1:0]    cursor_pos;
	logic [CELL_W-1:0]   cell_value;

	modport source (output valid, output cursor_col, output cursor_row, output cursor_pos,
		output cell_value, input ready);
	modport sink (input valid, input cursor_col, input cursor_row, input cursor_pos,
		input cell_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcce_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; used by the text console character engine for the screen store.
`timescale 1ns / 1ps
`default_nettype none

module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

// File: hw/rtl/text_console_char_engine_core.sv
// Text console character engine: screen store of attribute/character cells and cursor.
// Depends on tcce_pkg, tcce_cmd_if, tcce_res_if and tcce_ram.
// Each request is taken into the execute state. Set cursor, plain characters, newline,
// backspace and delete finish there unless they start a scroll; read cell goes on to the
// read state; tab blanks cells up to its stop; a scroll moves rows up, then blanks the last
// row; clear blanks every cell. A request is taken only in the idle state, so a new request
// is not taken before the last is through; a stalled result waits in the done state.
// After reset the store is swept to attribute 7 / space, one cell a cycle over all
// COLUMNS*ROWS cells (2000 by default); requests wait, configuration writes are taken.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_engine_core #(
	parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	tcce_cmd_if.sink                          cmd_ch,
	tcce_res_if.source                        res_ch,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tcce_pkg::APB_AW-1:0]  paddr,
	input  wire logic [tcce_pkg::APB_DW-1:0]  pwdata,
	output logic      [tcce_pkg::APB_DW-1:0]  prdata,
	output logic                              pready
);
	import tcce_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW    = $clog2(COLUMNS + 1);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = (AW > POS_W) ? AW : POS_W;

	localparam logic [CW-1:0] COLS_C      = CW'(COLUMNS);
	localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROWS_C      = RW'(ROWS);
	localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
	localparam logic [AW-1:0] LAST_A      = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_ROW_A  = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] SCROLL_END  = AW'(CELLS - COLUMNS - 1);
	localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);

	typedef enum logic [7:0] {
		ST_INIT   = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_EXEC   = 8'b0000_0100,
		ST_TAB    = 8'b0000_1000,
		ST_SCROLL = 8'b0001_0000,
		ST_FILL   = 8'b0010_0000,
		ST_READ   = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	function automatic logic [AW-1:0] lin_of(input logic [CW-1:0] c, input logic [RW-1:0] r);
		lin_of = AW'(r) * COLS_A + AW'(c);
	endfunction

	state_t            state_q, state_d;
	logic [CW-1:0]     cur_col_q, cur_col_d;
	logic [RW-1:0]     cur_row_q, cur_row_d;
	logic [ATTR_W-1:0] attr_q;
	cmd_t              cmd_q;
	logic [CHAR_W-1:0] char_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [AW-1:0]     fill_q, fill_d;
	logic [CW-1:0]     tab_end_q, tab_end_d;
	logic [CELL_W-1:0] cell_q, cell_d;
	logic              copy_s1, copy_d;
	logic [AW-1:0]     copy_addr_s1, copy_addr_d;

	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [CELL_W-1:0] out_cell_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [CELL_W-1:0] wdata, rdata;
	logic [CELL_W-1:0] blank;

	logic              in_take, slot_free, finish, load, post;
	logic [CW-1:0]     pc_col, wc, bs_col;
	logic [RW-1:0]     pc_row, wr, bs_row;
	logic [CW:0]       tab_next;
	logic [CW-1:0]     clamp_col;
	logic [RW-1:0]     clamp_row;
	logic [PW-1:0]     pos_w;

	assign blank     = {attr_q, CH_SPACE};
	assign in_take   = cmd_ch.valid && cmd_ch.ready;
	assign slot_free = !out_valid_q || res_ch.ready;
	assign cmd_ch.ready = (state_q == ST_IDLE);

	assign clamp_col = (int'(cmd_ch.col) > COLUMNS - 1) ? LAST_COL : CW'(cmd_ch.col);
	assign clamp_row = (int'(cmd_ch.row) > ROWS - 1) ? LAST_ROW : RW'(cmd_ch.row);

	always_comb begin
		state_d     = state_q;
		cur_col_d   = cur_col_q;
		cur_row_d   = cur_row_q;
		fill_d      = fill_q;
		tab_end_d   = tab_end_q;
		cell_d      = cell_q;
		copy_d      = 1'b0;
		copy_addr_d = fill_q;
		we          = 1'b0;
		waddr       = lin_of(cur_col_q, cur_row_q);
		wdata       = blank;
		raddr       = lin_of(col_q, row_q);
		finish      = 1'b0;
		post        = 1'b0;
		pc_col      = cur_col_q;
		pc_row      = cur_row_q;
		wc          = cur_col_q;
		wr          = cur_row_q;
		bs_col      = cur_col_q;
		bs_row      = cur_row_q;
		tab_next    = ({1'b0, cur_col_q} + (CW + 1)'(8)) & ~(CW + 1)'(7);

		case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = fill_q;
				wdata = CELL_RESET;
				if (fill_q == LAST_A) begin
					state_d = ST_IDLE;
				end else begin
					fill_d = fill_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (in_take) begin
					cell_d  = '0;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_PUT: begin
						case (char_q)
							CH_NEWLINE: begin
								pc_col = '0;
								pc_row = cur_row_q + RW'(1);
								post   = 1'b1;
							end
							CH_BACKSPACE: begin
								if (cur_col_q != '0) begin
									bs_col = cur_col_q - CW'(1);
								end else if (cur_row_q != '0) begin
									bs_col = LAST_COL;
									bs_row = cur_row_q - RW'(1);
								end
								we     = 1'b1;
								waddr  = lin_of(bs_col, bs_row);
								pc_col = bs_col;
								pc_row = bs_row;
								post   = 1'b1;
							end
							CH_DELETE: begin
								we   = 1'b1;
								post = 1'b1;
							end
							CH_TAB: begin
								// The stop is the next multiple of eight, held at the row end.
								if (tab_next > {1'b0, COLS_C}) begin
									tab_end_d = COLS_C;
								end else begin
									tab_end_d = tab_next[CW-1:0];
								end
								state_d = ST_TAB;
							end
							default: begin
								we     = 1'b1;
								wdata  = {attr_q, char_q};
								pc_col = cur_col_q + CW'(1);
								post   = 1'b1;
							end
						endcase
					end
					CMD_SET: begin
						cur_col_d = col_q;
						cur_row_d = row_q;
						finish    = 1'b1;
					end
					CMD_CLEAR: begin
						cur_col_d = '0;
						cur_row_d = '0;
						fill_d    = '0;
						state_d   = ST_FILL;
					end
					default: begin
						state_d = ST_READ;
					end
				endcase
			end
			ST_TAB: begin
				we        = 1'b1;
				cur_col_d = cur_col_q + CW'(1);
				if (cur_col_q + CW'(1) == tab_end_q) begin
					pc_col = tab_end_q;
					post   = 1'b1;
				end
			end
			ST_SCROLL: begin
				// Row r+1 moves to row r: read ahead, write in the cycle after.
				raddr       = fill_q + COLS_A;
				copy_d      = 1'b1;
				copy_addr_d = fill_q;
				fill_d      = fill_q + AW'(1);
				if (fill_q == SCROLL_END) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (!copy_s1) begin
					we    = 1'b1;
					waddr = fill_q;
					if (fill_q == LAST_A) begin
						finish = 1'b1;
					end else begin
						fill_d = fill_q + AW'(1);
					end
				end
			end
			ST_READ: begin
				cell_d = rdata;
				finish = 1'b1;
			end
			ST_DONE: begin
				finish = 1'b1;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase

		// Column overflow wraps to the next row; row overflow starts a scroll.
		if (post) begin
			if (pc_col >= COLS_C) begin
				wc = '0;
				wr = pc_row + RW'(1);
			end else begin
				wc = pc_col;
				wr = pc_row;
			end
			cur_col_d = wc;
			if (wr >= ROWS_C) begin
				cur_row_d = LAST_ROW;
				fill_d    = (ROWS > 1) ? '0 : LAST_ROW_A;
				state_d   = (ROWS > 1) ? ST_SCROLL : ST_FILL;
			end else begin
				cur_row_d = wr;
				finish    = 1'b1;
			end
		end

		// The last copy of a scroll owns the write port.
		if (copy_s1) begin
			we    = 1'b1;
			waddr = copy_addr_s1;
			wdata = rdata;
		end

		load = finish && slot_free;
		if (finish) begin
			state_d = slot_free ? ST_IDLE : ST_DONE;
		end

		pos_w = PW'(cur_row_d) * PW'(COLUMNS) + PW'(cur_col_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			attr_q      <= ATTR_RESET;
			fill_q      <= '0;
			copy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_col_q <= cur_col_d;
			cur_row_q <= cur_row_d;
			fill_q    <= fill_d;
			copy_s1   <= copy_d;
			if (psel && penable && pwrite && paddr[APB_AW-1] == REG_ATTR) begin
				attr_q <= pwdata[ATTR_W-1:0];
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tab_end_q    <= tab_end_d;
		cell_q       <= cell_d;
		copy_addr_s1 <= copy_addr_d;
		if (in_take) begin
			cmd_q  <= cmd_t'(cmd_ch.cmd);
			char_q <= cmd_ch.char_code;
			col_q  <= clamp_col;
			row_q  <= clamp_row;
		end
		if (load) begin
			out_col_q  <= COL_W'(cur_col_d);
			out_row_q  <= ROW_W'(cur_row_d);
			out_pos_q  <= pos_w[POS_W-1:0];
			out_cell_q <= cell_d;
		end
	end

	tcce_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign res_ch.valid      = out_valid_q;
	assign res_ch.cursor_col = out_col_q;
	assign res_ch.cursor_row = out_row_q;
	assign res_ch.cursor_pos = out_pos_q;
	assign res_ch.cell_value = out_cell_q;

	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1] == REG_ATTR) ? APB_DW'(attr_q) : '0;
endmodule

`default_nettype wire
